// ----- rtl/stt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg: shared types and codes for the software timer table
// Command codes, mode codes and the per-channel record layout.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int NUM_TIMERS_DEF = 8;
  localparam int OP_W           = 3;
  localparam int IDX_W          = 3;
  localparam int CNT_W          = 16;
  localparam int MODE_W         = 2;
  localparam int MASK_W         = 8;

  localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_W-1:0] OP_ARM       = 3'd1;
  localparam logic [OP_W-1:0] OP_PAUSE     = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP      = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;
  localparam logic [OP_W-1:0] OP_DELAY     = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd6;

  localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ONE_SHOT = 2'd1;

  typedef struct packed {
    logic              enable;
    logic [CNT_W-1:0]  delay;
    logic [CNT_W-1:0]  count;
    logic [MODE_W-1:0] mode;
  } chan_rec_t;

endpackage

// ----- rtl/stt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_if: command and result channels of the software timer table
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface stt_in_if import stt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [IDX_W-1:0]  timer_index;
  logic [CNT_W-1:0]  delay_value;
  logic [MODE_W-1:0] timer_mode;

  modport source (output valid, op, timer_index, delay_value, timer_mode, input ready);
  modport sink   (input valid, op, timer_index, delay_value, timer_mode, output ready);
endinterface

interface stt_out_if import stt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] fired_mask;

  modport source (output valid, fired_mask, input ready);
  modport sink   (input valid, fired_mask, output ready);
endinterface

// ----- rtl/stt_chan_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_chan_mem: channel record store
// One write and one registered read port; per-entry valid bits make an
// unwritten entry read as the all-zero reset record.
// ----------------------------------------------------------------------------
module stt_chan_mem import stt_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int IW         = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      rd_en,
  input  logic [IW-1:0] rd_addr,
  output chan_rec_t rd_data,
  input  logic      wr_en,
  input  logic [IW-1:0] wr_addr,
  input  chan_rec_t wr_data
);

  chan_rec_t                mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]    vld_r;
  chan_rec_t                rd_data_r;
  logic                     rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// ----- rtl/stt_chan_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_chan_alu: shared channel update unit
// Applies one command to one channel record: increment and compare on a
// tick, field updates for the channel commands.
// ----------------------------------------------------------------------------
module stt_chan_alu import stt_pkg::*; (
  input  logic [OP_W-1:0]   op,
  input  chan_rec_t         rec,
  input  logic [CNT_W-1:0]  delay_value,
  input  logic [MODE_W-1:0] timer_mode,
  output chan_rec_t         rec_nxt,
  output logic              fired
);

  logic [CNT_W-1:0] cnt_inc;

  assign cnt_inc = rec.count + CNT_W'(1);

  always_comb begin
    rec_nxt = rec;
    fired   = 1'b0;
    case (op)
      OP_TICK: begin
        if (rec.enable) begin
          rec_nxt.count = cnt_inc;
          if (cnt_inc == rec.delay && rec.mode != MODE_NONE) begin
            fired         = 1'b1;
            rec_nxt.count = '0;
            if (rec.mode == MODE_ONE_SHOT) begin
              rec_nxt = '0;
            end
          end
        end
      end
      OP_ARM: begin
        rec_nxt.enable = 1'b1;
        rec_nxt.delay  = delay_value;
        rec_nxt.count  = '0;
        rec_nxt.mode   = timer_mode;
      end
      OP_PAUSE: begin
        rec_nxt.enable = 1'b0;
      end
      OP_STOP: begin
        rec_nxt = '0;
      end
      OP_CLEAR, OP_CLEAR_ALL: begin
        rec_nxt.count = '0;
      end
      OP_DELAY: begin
        rec_nxt.count = '0;
        rec_nxt.delay = delay_value;
      end
      default: begin
        rec_nxt = rec;
      end
    endcase
  end

endmodule

// ----- rtl/software_timer_table.sv -----
`timescale 1ns / 1ps
// A tick passes through load, a walk over every channel and emit; its fired mask is
// registered as the result beat, and emit waits while the result channel is full. A new
// command is taken only in idle; the walk takes one channel per cycle through the
// single record read port. Unused codes and out-of-range channels are dropped in idle.
// Reset: synchronous, active low; every channel reads as stopped at once.
// ----------------------------------------------------------------------------
// software_timer_table: multi-channel one-shot / periodic timer table
// A small sequencer walks the channel records through one shared update unit.
// ----------------------------------------------------------------------------
module software_timer_table import stt_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  stt_in_if.sink    in_chan,
  stt_out_if.source out_chan
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_WALK = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [OP_W-1:0]   op_r;
  logic [CNT_W-1:0]  dly_r;
  logic [MODE_W-1:0] mode_r;
  logic [IW-1:0]     cur_r, cur_nxt;
  logic [IW-1:0]     last_r;
  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0] out_mask_r;

  logic      in_beat;
  logic      whole_table;
  logic      cmd_valid;
  logic      rd_en;
  logic [IW-1:0] rd_addr;
  chan_rec_t rd_data;
  logic      wr_en;
  chan_rec_t rec_nxt;
  logic      fired;
  logic      out_free;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_beat       = in_chan.valid && in_chan.ready;
  assign whole_table   = (in_chan.op == OP_TICK) || (in_chan.op == OP_CLEAR_ALL);
  assign cmd_valid     = whole_table ||
                         ((in_chan.op == OP_ARM || in_chan.op == OP_PAUSE ||
                           in_chan.op == OP_STOP || in_chan.op == OP_CLEAR ||
                           in_chan.op == OP_DELAY) &&
                          (32'(in_chan.timer_index) < NUM_TIMERS));

  assign rd_en   = (state_r == ST_LOAD) || (state_r == ST_WALK && cur_r != last_r);
  assign rd_addr = (state_r == ST_LOAD) ? cur_r : IW'(cur_r + IW'(1));
  assign wr_en   = (state_r == ST_WALK);
  assign out_free = !out_valid_r || out_chan.ready;

  stt_chan_mem #(.NUM_TIMERS(NUM_TIMERS), .IW(IW)) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (cur_r),
    .wr_data (rec_nxt)
  );

  stt_chan_alu u_alu (
    .op          (op_r),
    .rec         (rd_data),
    .delay_value (dly_r),
    .timer_mode  (mode_r),
    .rec_nxt     (rec_nxt),
    .fired       (fired)
  );

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    case (state_r)
      ST_IDLE: begin
        if (in_beat && cmd_valid) begin
          state_nxt = ST_LOAD;
          mask_nxt  = '0;
          cur_nxt   = whole_table ? '0 : IW'(in_chan.timer_index);
        end
      end
      ST_LOAD: begin
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        mask_nxt = mask_r | (MASK_W'(fired) << cur_r);
        if (cur_r == last_r) begin
          state_nxt = (op_r == OP_TICK) ? ST_EMIT : ST_IDLE;
        end else begin
          cur_nxt = IW'(cur_r + IW'(1));
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    mask_r <= mask_nxt;
    if (in_beat) begin
      op_r   <= in_chan.op;
      dly_r  <= in_chan.delay_value;
      mode_r <= in_chan.timer_mode;
      last_r <= whole_table ? LAST_IDX : IW'(in_chan.timer_index);
    end
    if (state_r == ST_EMIT && out_free) begin
      out_mask_r <= mask_r;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.fired_mask = out_mask_r;

endmodule

// ----- tb/sv/tb_software_timer_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_software_timer_table: self-checking bench for the software timer table
// Drives a short table of directed commands and then random command streams
// under four idling patterns.
// A behavioural copy of the channel table predicts each fired mask that the
// directed table does not give, and every result beat is checked in order.
// ----------------------------------------------------------------------------
module tb_software_timer_table;
  import stt_pkg::*;

  localparam int NUM_T          = NUM_TIMERS_DEF;
  localparam int RAND_PER_PHASE = 225;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = NUM_T + 6;

  localparam logic [OP_W-1:0]   OP_UNUSED     = 3'd7;
  localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE    = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  dly;
    logic [MODE_W-1:0] mode;
  } cmd_t;

  typedef struct {
    cmd_t              c;
    bit                known;
    logic [MASK_W-1:0] mask;
  } dir_row_t;

  logic clk;
  logic rst_n;

  stt_in_if  cmd_if ();
  stt_out_if mask_if ();

  software_timer_table #(.NUM_TIMERS(NUM_T)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (cmd_if),
    .out_chan (mask_if)
  );

  // channel table copy
  bit                ch_en  [NUM_T];
  logic [CNT_W-1:0]  ch_dly [NUM_T];
  logic [CNT_W-1:0]  ch_cnt [NUM_T];
  logic [MODE_W-1:0] ch_md  [NUM_T];

  logic [MASK_W-1:0] fired_q [$];

  int send_idle_pct;
  int rx_stall_pct;
  bit row_known;
  logic [MASK_W-1:0] row_mask;
  int fail_count;
  int n_cmds;
  int n_ticks;
  int n_fires;
  int idle_cycles;

  dir_row_t dir_table [24] = '{
    '{'{OP_TICK,      3'd0, 16'h0000, MODE_NONE},     1'b1, 8'h00},
    '{'{OP_ARM,       3'd0, 16'h0001, MODE_ONE_SHOT}, 1'b0, 8'h00},
    '{'{OP_TICK,      3'd0, 16'h0000, MODE_NONE},     1'b1, 8'h01},
    '{'{OP_TICK,      3'd0, 16'h0000, MODE_NONE},     1'b1, 8'h00},
    '{'{OP_ARM,       3'd7, 16'h0002, MODE_PERIODIC}, 1'b0, 8'h00},
    '{'{OP_ARM,       3'd3, 16'h0001, MODE_SPARE},    1'b0, 8'h00},
    '{'{OP_TICK,      3'd0, 16'h0000, MODE_NONE},     1'b1, 8'h08},
    '{'{OP_TICK,      3'd0, 16'h0000, MODE_NONE},     1'b1, 8'h88},
    '{'{OP_PAUSE,     3'd3, 16'h0000, MODE_NONE},     1'b0, 8'h00},
    '{'{OP_ARM,       3'd1, 16'h0001, MODE_NONE},     1'b0, 8'h00},
    '{'{OP_TICK,      3'd0, 16'h0000, MODE_NONE},     1'b1, 8'h00},
    '{'{OP_TICK,      3'd0, 16'h0000, MODE_NONE},     1'b1, 8'h80},
    '{'{OP_CLEAR,     3'd1, 16'h0000, MODE_NONE},     1'b0, 8'h00},
    '{'{OP_DELAY,     3'd7, 16'hffff, MODE_NONE},     1'b0, 8'h00},
    '{'{OP_TICK,      3'd0, 16'h0000, MODE_NONE},     1'b0, 8'h00},
    '{'{OP_UNUSED,    3'd5, 16'hffff, MODE_SPARE},    1'b0, 8'h00},
    '{'{OP_STOP,      3'd7, 16'h0000, MODE_NONE},     1'b0, 8'h00},
    '{'{OP_ARM,       3'd5, 16'hffff, MODE_ONE_SHOT}, 1'b0, 8'h00},
    '{'{OP_CLEAR_ALL, 3'd0, 16'h0000, MODE_NONE},     1'b0, 8'h00},
    '{'{OP_ARM,       3'd2, 16'h0003, MODE_PERIODIC}, 1'b0, 8'h00},
    '{'{OP_TICK,      3'd0, 16'h0000, MODE_NONE},     1'b0, 8'h00},
    '{'{OP_TICK,      3'd0, 16'h0000, MODE_NONE},     1'b0, 8'h00},
    '{'{OP_TICK,      3'd0, 16'h0000, MODE_NONE},     1'b0, 8'h00},
    '{'{OP_STOP,      3'd2, 16'h0000, MODE_NONE},     1'b0, 8'h00}
  };

  always #5 clk = ~clk;

  function automatic void stop_chan(int k);
    ch_en[k]  = 1'b0;
    ch_dly[k] = '0;
    ch_cnt[k] = '0;
    ch_md[k]  = MODE_NONE;
  endfunction

  function automatic logic [MASK_W-1:0] tick_table();
    logic [MASK_W-1:0] m;
    m = '0;
    for (int k = 0; k < NUM_T; k++) begin
      if (ch_en[k]) begin
        ch_cnt[k] = ch_cnt[k] + 1'b1;
        if (ch_cnt[k] == ch_dly[k] && ch_md[k] != MODE_NONE) begin
          ch_cnt[k] = '0;
          if (ch_md[k] == MODE_ONE_SHOT) stop_chan(k);
          if (k < MASK_W) m[k] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  function automatic void apply_command(cmd_t c, output bit gives, output logic [MASK_W-1:0] m);
    int k;
    gives = 1'b0;
    m     = '0;
    k     = int'(c.idx);
    if (c.op == OP_TICK) begin
      gives = 1'b1;
      m     = tick_table();
    end else if (c.op == OP_CLEAR_ALL) begin
      for (int j = 0; j < NUM_T; j++) ch_cnt[j] = '0;
    end else if (k < NUM_T) begin
      case (c.op)
        OP_ARM: begin
          ch_dly[k] = c.dly;
          ch_cnt[k] = '0;
          ch_md[k]  = c.mode;
          ch_en[k]  = 1'b1;
        end
        OP_PAUSE: ch_en[k] = 1'b0;
        OP_STOP:  stop_chan(k);
        OP_CLEAR: ch_cnt[k] = '0;
        OP_DELAY: begin
          ch_cnt[k] = '0;
          ch_dly[k] = c.dly;
        end
        default: ;
      endcase
    end
  endfunction

  function automatic cmd_t random_command();
    cmd_t c;
    int pick;
    pick   = $urandom_range(99);
    c.idx  = IDX_W'($urandom);
    c.dly  = ($urandom_range(3) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(8));
    c.mode = MODE_W'($urandom);
    if (pick < 45)      c.op = OP_TICK;
    else if (pick < 65) c.op = OP_ARM;
    else if (pick < 72) c.op = OP_PAUSE;
    else if (pick < 77) c.op = OP_STOP;
    else if (pick < 84) c.op = OP_CLEAR;
    else if (pick < 92) c.op = OP_DELAY;
    else if (pick < 97) c.op = OP_CLEAR_ALL;
    else                c.op = OP_UNUSED;
    return c;
  endfunction

  function automatic void report(string what, logic [MASK_W-1:0] want, logic [MASK_W-1:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t mismatch (%s): fired_mask expected %02h got %02h", $realtime, what, want, got);
  endfunction

  task automatic send_command(cmd_t c, bit known, logic [MASK_W-1:0] kmask);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.op          <= c.op;
    cmd_if.timer_index <= c.idx;
    cmd_if.delay_value <= c.dly;
    cmd_if.timer_mode  <= c.mode;
    row_known = known;
    row_mask  = kmask;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold the sender until every fired mask is back, then let the walk finish
  task automatic drain();
    cmd_if.valid <= 1'b0;
    while (fired_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    mask_if.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    cmd_t cur;
    bit gives;
    logic [MASK_W-1:0] want;
    if (rst_n) begin
      if (mask_if.valid && mask_if.ready) begin
        if (fired_q.size() == 0) begin
          report("no tick outstanding", '0, mask_if.fired_mask);
        end else begin
          want = fired_q.pop_front();
          if (mask_if.fired_mask !== want) report("fired_mask", want, mask_if.fired_mask);
          n_fires += $countones(want);
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        cur.op   = cmd_if.op;
        cur.idx  = cmd_if.timer_index;
        cur.dly  = cmd_if.delay_value;
        cur.mode = cmd_if.timer_mode;
        apply_command(cur, gives, want);
        n_cmds++;
        if (gives) begin
          n_ticks++;
          fired_q.push_back(row_known ? row_mask : want);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (mask_if.valid && mask_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d masks outstanding",
               idle_cycles, fired_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    cmd_t c;
    int counted;
    clk                = 1'b0;
    rst_n              = 1'b0;
    cmd_if.valid       = 1'b0;
    cmd_if.op          = OP_TICK;
    cmd_if.timer_index = '0;
    cmd_if.delay_value = '0;
    cmd_if.timer_mode  = MODE_NONE;
    mask_if.ready      = 1'b0;
    send_idle_pct      = 0;
    rx_stall_pct       = 0;
    row_known          = 1'b0;
    row_mask           = '0;
    fail_count         = 0;
    n_cmds             = 0;
    n_ticks            = 0;
    n_fires            = 0;
    idle_cycles        = 0;
    for (int k = 0; k < NUM_T; k++) stop_chan(k);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_table[i]) send_command(dir_table[i].c, dir_table[i].known, dir_table[i].mask);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin send_idle_pct = 50; rx_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rx_stall_pct = 50; end
        default: begin send_idle_pct = 9; rx_stall_pct = 9; end
      endcase
      counted = 0;
      while (counted < RAND_PER_PHASE) begin
        c = random_command();
        send_command(c, 1'b0, '0);
        if (c.op != OP_UNUSED) counted++;
      end
      drain();
    end

    fail_count += fired_q.size();
    $display("covered: %0d commands, %0d ticks checked, %0d channel firings",
             n_cmds, n_ticks, n_fires);
    $display("directed table and four idling mixes of random commands; %0d failures",
             fail_count);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/stt_pkg.sv
rtl/stt_if.sv
rtl/stt_chan_mem.sv
rtl/stt_chan_alu.sv
rtl/software_timer_table.sv
tb/sv/tb_software_timer_table.sv
